// ===== rtl/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared types and codes for the bilinear plasticity material point.
// ----------------------------------------------------------------------------
package bpp_pkg;

    // request kinds
    localparam logic [1:0] REQ_TRIAL    = 2'd0;
    localparam logic [1:0] REQ_COMMIT   = 2'd1;
    localparam logic [1:0] REQ_ROLLBACK = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_EPOCH    = 2'd1;
    localparam logic [1:0] STS_NOMATCH  = 2'd2;
    localparam logic [1:0] STS_OVF      = 2'd3;

    // multiplier operand selects, also used as the accumulate action in the following cycle
    localparam logic [3:0] MS_EMAG   = 4'd0;  // E * |strain - committed plastic|
    localparam logic [3:0] MS_ER     = 4'd1;  // E * R
    localparam logic [3:0] MS_DPLO   = 4'd2;  // D * low half of E*|d|
    localparam logic [3:0] MS_DPHI   = 4'd3;  // D * high half of E*|d|
    localparam logic [3:0] MS_DY     = 4'd4;  // D * yield stress
    localparam logic [3:0] MS_ERLO   = 4'd5;  // low half of E*R * accumulated strain
    localparam logic [3:0] MS_ERHI   = 4'd6;  // high half of E*R * accumulated strain
    localparam logic [3:0] MS_NONE   = 4'd7;
    localparam logic [3:0] MS_STRESS = 4'd8;  // E * |strain - new plastic|

    // quotient bits of the plastic increment
    localparam logic [5:0] DIV_STEPS = 6'd33;

    // register reset values
    localparam logic [29:0] E_RESET = 30'd200000000;
    localparam logic [29:0] Y_RESET = 30'd250000;
    localparam logic [15:0] R_RESET = 16'd0;

    // register indexes
    localparam logic [1:0] CFG_E = 2'd0;
    localparam logic [1:0] CFG_Y = 2'd1;
    localparam logic [1:0] CFG_R = 2'd2;

    typedef struct packed {
        logic       load;
        logic [3:0] mul_sel;
        logic       div_init;
        logic       div_step;
        logic       sat;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic trial_go;
        logic yield;
        logic out_busy;
    } stat_t;

endpackage

// ===== rtl/bpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpp_ctrl
// Sequencer for one request: multiply schedule, divide loop, result handoff.
// ----------------------------------------------------------------------------
module bpp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output bpp_pkg::cmd_t   cmd,
    input  bpp_pkg::stat_t  stat
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_YCHK   = 4'd3;
    localparam logic [3:0] ST_DIVI   = 4'd4;
    localparam logic [3:0] ST_DIV    = 4'd5;
    localparam logic [3:0] ST_SAT    = 4'd6;
    localparam logic [3:0] ST_SMUL   = 4'd7;
    localparam logic [3:0] ST_SACC   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.mul_sel  = bpp_pkg::MS_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cnt_next   = '0;
                state_next = stat.trial_go ? ST_MUL : ST_FIN;
            end
            ST_MUL: begin
                cmd.mul_sel = {1'b0, cnt_reg[2:0]};
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7) begin
                    state_next = ST_YCHK;
                end
            end
            ST_YCHK: begin
                state_next = stat.yield ? ST_DIVI : ST_SAT;
            end
            ST_DIVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == bpp_pkg::DIV_STEPS - 6'd1) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                cmd.sat    = 1'b1;
                state_next = ST_SMUL;
            end
            ST_SMUL: begin
                cmd.mul_sel = bpp_pkg::MS_STRESS;
                state_next  = ST_SACC;
            end
            ST_SACC: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // divide loop never runs past its last quotient bit
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg < bpp_pkg::DIV_STEPS)
        else $error("divide counter out of range");

    // a result is only handed over while the output word can take it
    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !stat.out_busy && state_reg == ST_FIN)
        else $error("finish issued with busy output");

endmodule

// ===== rtl/bpp_datapath.sv =====
// ----------------------------------------------------------------------------
// bpp_datapath
// Shared multiplier, yield accumulator, restoring divider, point state and
// the registered output word.
// ----------------------------------------------------------------------------
module bpp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpp_pkg::cmd_t       cmd,
    output bpp_pkg::stat_t      stat,
    input  logic [29:0]         youngs_modulus,
    input  logic [29:0]         yield_stress,
    input  logic [15:0]         hard_ratio,
    input  logic [1:0]          in_req_type,
    input  logic signed [31:0]  in_total_strain,
    input  logic [63:0]         in_step_epoch,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [207:0]        m_tdata,
    output logic [1:0]          m_tuser
);

    // request capture
    logic [1:0]         req_reg;
    logic signed [31:0] strain_reg;
    logic [63:0]        epoch_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;

    // point state
    logic [31:0] com_p_reg, com_a_reg, pend_p_reg, pend_a_reg;
    logic [63:0] com_step_reg, pend_step_reg;
    logic        pend_valid_reg;

    // arithmetic
    logic [3:0]         sel_reg;
    logic [64:0]        prod_reg;
    logic [62:0]        pmag_reg;
    logic [45:0]        er_reg;
    logic signed [80:0] acc_reg;
    logic [29:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [31:0]        newp_reg, newa_reg;
    logic               ovf_reg, yld_reg, sneg_reg;
    logic [29:0]        tan_reg;
    logic [47:0]        stress_reg;

    // output word
    logic         o_valid_reg;
    logic [207:0] o_data_reg;
    logic [1:0]   o_user_reg;

    logic [16:0]  d_fac;
    logic [32:0]  mul_a;
    logic [31:0]  mul_b;
    logic [80:0]  prod_ext;
    logic         next_ok, yield, commit_ok;
    logic [32:0]  d_load, d_stress, smag;

    assign d_fac    = 17'd65536 - {1'b0, hard_ratio};
    assign prod_ext = {16'd0, prod_reg};
    assign next_ok  = (com_step_reg != '1) && (epoch_reg == com_step_reg + 64'd1);
    assign yield    = !acc_reg[80] && (acc_reg != '0);
    assign commit_ok = (req_reg == bpp_pkg::REQ_COMMIT || req_reg == bpp_pkg::REQ_ROLLBACK)
                       && pend_valid_reg && (pend_step_reg == epoch_reg) && next_ok;

    assign stat.trial_go = (req_reg == bpp_pkg::REQ_TRIAL) && next_ok;
    assign stat.yield    = yield;
    assign stat.out_busy = o_valid_reg && !m_tready;

    // strain differences and magnitudes
    assign d_load   = {in_total_strain[31], in_total_strain} - {com_p_reg[31], com_p_reg};
    assign d_stress = {strain_reg[31], strain_reg} - {newp_reg[31], newp_reg};
    assign smag     = d_stress[32] ? (33'd0 - d_stress) : d_stress;

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= in_req_type;
            strain_reg <= in_total_strain;
            epoch_reg  <= in_step_epoch;
            neg_reg    <= d_load[32];
            mag_reg    <= d_load[32] ? (33'd0 - d_load) : d_load;
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            bpp_pkg::MS_EMAG: begin
                mul_a = mag_reg;
                mul_b = {2'd0, youngs_modulus};
            end
            bpp_pkg::MS_ER: begin
                mul_a = {3'd0, youngs_modulus};
                mul_b = {16'd0, hard_ratio};
            end
            bpp_pkg::MS_DPLO: begin
                mul_a = {16'd0, d_fac};
                mul_b = pmag_reg[31:0];
            end
            bpp_pkg::MS_DPHI: begin
                mul_a = {16'd0, d_fac};
                mul_b = {1'b0, pmag_reg[62:32]};
            end
            bpp_pkg::MS_DY: begin
                mul_a = {16'd0, d_fac};
                mul_b = {2'd0, yield_stress};
            end
            bpp_pkg::MS_ERLO: begin
                mul_a = {1'b0, er_reg[31:0]};
                mul_b = com_a_reg;
            end
            bpp_pkg::MS_ERHI: begin
                mul_a = {19'd0, er_reg[45:32]};
                mul_b = com_a_reg;
            end
            bpp_pkg::MS_STRESS: begin
                mul_a = smag;
                mul_b = {2'd0, youngs_modulus};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product register and select pipeline
    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, mul_a} * {33'd0, mul_b};
        if (!aresetn) begin
            sel_reg <= bpp_pkg::MS_NONE;
        end else begin
            sel_reg <= cmd.mul_sel;
        end
    end

    // accumulate the yield function F = D*|P| - D*Y*2^30 - E*R*accum
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            acc_reg <= '0;
        end else begin
            case (sel_reg)
                bpp_pkg::MS_EMAG:   pmag_reg <= prod_reg[62:0];
                bpp_pkg::MS_ER:     er_reg   <= prod_reg[45:0];
                bpp_pkg::MS_DPLO:   acc_reg  <= acc_reg + $signed(prod_ext);
                bpp_pkg::MS_DPHI:   acc_reg  <= acc_reg + $signed(prod_ext << 32);
                bpp_pkg::MS_DY:     acc_reg  <= acc_reg - $signed(prod_ext << 30);
                bpp_pkg::MS_ERLO:   acc_reg  <= acc_reg - $signed(prod_ext);
                bpp_pkg::MS_ERHI:   acc_reg  <= acc_reg - $signed(prod_ext << 32);
                bpp_pkg::MS_STRESS: begin
                    stress_reg <= sneg_reg ? (48'd0 - {15'd0, prod_reg[62:30]})
                                           : {15'd0, prod_reg[62:30]};
                end
                default: ;
            endcase
        end
        if (cmd.mul_sel == bpp_pkg::MS_STRESS) begin
            sneg_reg <= d_stress[32];
        end
    end

    // restoring divide of F/65536 by E, one quotient bit a cycle
    logic [30:0] div_t;
    logic [30:0] div_d;
    logic        div_ge;
    assign div_t  = {rem_reg, quo_reg[32]};
    assign div_ge = div_t >= {1'b0, youngs_modulus};
    assign div_d  = div_t - {1'b0, youngs_modulus};

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= acc_reg[78:49];
            quo_reg <= acc_reg[48:16];
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? div_d[29:0] : div_t[29:0];
            quo_reg <= {quo_reg[31:0], div_ge};
        end
    end

    // new plastic and accumulated strain with saturation
    logic [32:0]        delta;
    logic signed [34:0] cp35, np35;
    logic [33:0]        na34;
    logic               p_hi, p_lo, a_hi;
    assign delta = yield ? quo_reg : 33'd0;
    assign cp35  = {{3{com_p_reg[31]}}, com_p_reg};
    assign np35  = neg_reg ? (cp35 - $signed({2'd0, delta})) : (cp35 + $signed({2'd0, delta}));
    assign na34  = {2'd0, com_a_reg} + {1'b0, delta};
    assign p_hi  = np35 > 35'sd2147483647;
    assign p_lo  = np35 < -35'sd2147483648;
    assign a_hi  = na34[33:32] != 2'd0;

    always_ff @(posedge aclk) begin
        if (cmd.sat) begin
            newp_reg <= p_hi ? 32'h7FFF_FFFF : (p_lo ? 32'h8000_0000 : np35[31:0]);
            newa_reg <= a_hi ? 32'hFFFF_FFFF : na34[31:0];
            ovf_reg  <= p_hi | p_lo | a_hi;
            yld_reg  <= yield;
            tan_reg  <= yield ? er_reg[45:16] : youngs_modulus;
        end
    end

    // result word
    logic [47:0] r_stress;
    logic [29:0] r_tan;
    logic [31:0] r_p, r_a;
    logic        r_y;
    logic [1:0]  r_sts;
    always_comb begin
        r_stress = '0;
        r_tan    = '0;
        r_p      = '0;
        r_a      = '0;
        r_y      = 1'b0;
        r_sts    = bpp_pkg::STS_NOMATCH;
        if (req_reg == bpp_pkg::REQ_TRIAL) begin
            if (!next_ok) begin
                r_sts = bpp_pkg::STS_EPOCH;
            end else begin
                r_stress = stress_reg;
                r_tan    = tan_reg;
                r_p      = newp_reg;
                r_a      = newa_reg;
                r_y      = yld_reg;
                r_sts    = ovf_reg ? bpp_pkg::STS_OVF : bpp_pkg::STS_OK;
            end
        end else if (commit_ok) begin
            r_p   = pend_p_reg;
            r_a   = pend_a_reg;
            r_sts = bpp_pkg::STS_OK;
        end
    end

    // point state update
    logic trial_keep;
    assign trial_keep = cmd.finish && stat.trial_go && !ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            com_p_reg      <= '0;
            com_a_reg      <= '0;
            com_step_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end else if (trial_keep) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.finish && commit_ok) begin
            pend_valid_reg <= 1'b0;
            if (req_reg == bpp_pkg::REQ_COMMIT) begin
                com_p_reg    <= pend_p_reg;
                com_a_reg    <= pend_a_reg;
                com_step_reg <= epoch_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (trial_keep) begin
            pend_p_reg    <= newp_reg;
            pend_a_reg    <= newa_reg;
            pend_step_reg <= epoch_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            o_valid_reg <= 1'b1;
        end else if (m_tready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_data_reg <= {1'b0, epoch_reg, r_y, r_a, r_p, r_tan, r_stress};
            o_user_reg <= r_sts;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = o_user_reg;

    // remainder stays below the divisor through the divide loop
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> rem_reg < youngs_modulus)
        else $error("divider remainder not below modulus");

    // a yielding point always has a nonzero modulus to divide by
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_init |-> youngs_modulus != 30'd0)
        else $error("divide started with zero modulus");

    // a new output word only follows a finished request
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(o_valid_reg) |-> $past(cmd.finish))
        else $error("output word without finished request");

endmodule

// ===== rtl/bilinear_plasticity_point.sv =====
// ----------------------------------------------------------------------------
// bilinear_plasticity_point
// Uniaxial material point with bilinear isotropic hardening and
// trial / commit / rollback state.
//
//   channel   direction  contents
//   s_        in         tuser: req_type; tdata: total_strain, step_epoch
//   m_        out        tuser: status; tdata: stress .. echo_epoch
//   cfg_      in         register index and write data, no read-back
//
// A yielding trial runs from accept through decide, eight yield-check
// multiplies and a yield check, divider setup and 33 quotient bits,
// saturate, stress multiply and accumulate, then handoff. An elastic trial
// skips the divider; commit, rollback and rejected requests go from decide
// straight to handoff. Input is ready again in the cycle after handoff. Reset
// is synchronous on aresetn low; it clears committed state and pending flag.
// A finished word waits in the output register while the next request is
// taken; the sequencer holds its result only when that register is still full.
// ----------------------------------------------------------------------------
module bilinear_plasticity_point (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // total_strain[31:0], step_epoch[95:32]
    input  logic [1:0]   s_tuser,   // req_type[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // stress[47:0], tangent[77:48],
                                    // plastic[109:78],
                                    // accum_plastic[141:110],
                                    // yielded[142], echo_epoch[206:143], zero[207]
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [29:0]  cfg_wdata
);

    logic [29:0] e_reg, y_reg;
    logic [15:0] r_reg;
    bpp_pkg::cmd_t  cmd;
    bpp_pkg::stat_t stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg <= bpp_pkg::E_RESET;
            y_reg <= bpp_pkg::Y_RESET;
            r_reg <= bpp_pkg::R_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bpp_pkg::CFG_E: e_reg <= cfg_wdata;
                bpp_pkg::CFG_Y: y_reg <= cfg_wdata;
                bpp_pkg::CFG_R: r_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    bpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bpp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .youngs_modulus  (e_reg),
        .yield_stress    (y_reg),
        .hard_ratio      (r_reg),
        .in_req_type     (s_tuser),
        .in_total_strain (s_tdata[31:0]),
        .in_step_epoch   (s_tdata[95:32]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser)
    );

endmodule

// ===== tb/sv/bilinear_plasticity_point_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_plasticity_point_tb
// Checks the plasticity point against an in-bench predictor of the
// trial / commit / rollback protocol: directed corner words first, then
// random epoch-consistent sequences mixed with noise, over several register
// settings and three idling profiles on the input and result streams.
// ----------------------------------------------------------------------------
module bilinear_plasticity_point_tb;

    typedef struct packed {
        logic [47:0] stress;
        logic [29:0] tangent;
        logic [31:0] plastic;
        logic [31:0] accum;
        logic        yielded;
        logic [63:0] epoch;
        logic [1:0]  status;
    } point_result_t;

    // material point predictor and store of expected words
    class point_scoreboard;
        logic [29:0] e_mod, y_str;
        logic [15:0] r_ratio;
        logic [31:0] c_plastic, c_accum;
        logic [63:0] c_step;
        bit          p_valid;
        logic [31:0] p_plastic, p_accum;
        logic [63:0] p_step;
        point_result_t awaited[$];
        int unsigned errors, checked;

        function new();
            e_mod = bpp_pkg::E_RESET; y_str = bpp_pkg::Y_RESET; r_ratio = bpp_pkg::R_RESET;
            c_plastic = 0; c_accum = 0; c_step = 0; p_valid = 0;
            p_plastic = 0; p_accum = 0; p_step = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [29:0] val);
            case (idx)
                bpp_pkg::CFG_E: e_mod = val;
                bpp_pkg::CFG_Y: y_str = val;
                bpp_pkg::CFG_R: r_ratio = val[15:0];
                default: ;
            endcase
        endfunction

        // predict the word for one accepted request
        function void note_request(logic [1:0] kind, logic [31:0] strain, logic [63:0] ep);
            point_result_t res;
            bit next_ok;
            logic signed [63:0] dd, newp, st;
            logic [63:0] mag, pmag, dd16, delta, e_div;
            logic [127:0] lhs, rhs, f;
            logic [64:0] newa;
            bit ovf;
            res = '0;
            res.epoch = ep;
            next_ok = (c_step != '1) && (ep == c_step + 64'd1);
            if (kind == bpp_pkg::REQ_TRIAL) begin
                if (!next_ok) begin
                    res.status = bpp_pkg::STS_EPOCH;
                end else begin
                    dd = $signed(strain) - $signed(c_plastic);
                    mag = dd < 0 ? -dd : dd;
                    pmag = 64'(e_mod) * mag;
                    dd16 = 64'd65536 - r_ratio;
                    lhs = 128'(dd16) * 128'(pmag);
                    rhs = 128'(dd16) * (128'(y_str) << 30)
                        + 128'(64'(e_mod) * r_ratio) * 128'(c_accum);
                    newp = $signed(c_plastic);
                    newa = c_accum;
                    res.tangent = e_mod;
                    ovf = 0;
                    if (lhs > rhs) begin
                        f = lhs - rhs;
                        e_div = e_mod == 0 ? 64'd1 : 64'(e_mod);
                        delta = 64'(f >> 16) / e_div;
                        newp = dd < 0 ? newp - $signed(delta) : newp + $signed(delta);
                        newa = newa + delta;
                        if (newp > 64'sd2147483647) begin
                            newp = 64'sd2147483647; ovf = 1;
                        end
                        if (newp < -64'sd2147483648) begin
                            newp = -64'sd2147483648; ovf = 1;
                        end
                        if (newa > 65'hFFFFFFFF) begin
                            newa = 65'hFFFFFFFF; ovf = 1;
                        end
                        res.tangent = 30'((64'(r_ratio) * e_mod) >> 16);
                        res.yielded = 1;
                    end
                    dd = $signed(strain) - newp;
                    mag = dd < 0 ? -dd : dd;
                    st = $signed((64'(e_mod) * mag) >> 30);
                    res.stress = 48'(dd < 0 ? -st : st);
                    res.plastic = newp[31:0];
                    res.accum = newa[31:0];
                    if (ovf) begin
                        res.status = bpp_pkg::STS_OVF;
                    end else begin
                        p_valid = 1; p_plastic = newp[31:0]; p_accum = newa[31:0];
                        p_step = ep;
                    end
                end
            end else if (kind != bpp_pkg::REQ_COMMIT && kind != bpp_pkg::REQ_ROLLBACK
                         || !p_valid || p_step != ep || !next_ok) begin
                res.status = bpp_pkg::STS_NOMATCH;
            end else begin
                res.plastic = p_plastic;
                res.accum = p_accum;
                if (kind == bpp_pkg::REQ_COMMIT) begin
                    c_plastic = p_plastic; c_accum = p_accum; c_step = ep;
                end
                p_valid = 0;
            end
            awaited.push_back(res);
        endfunction

        function void check_word(point_result_t got);
            point_result_t want;
            bit bad;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
                return;
            end
            want = awaited.pop_front();
            checked++;
            bad = got.stress != want.stress || got.tangent != want.tangent
                || got.plastic != want.plastic || got.accum != want.accum
                || got.yielded != want.yielded || got.epoch != want.epoch
                || got.status != want.status;
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch epoch %0d: expected %s",
                        want.epoch, "st sig tan ep ea y");
                    $display("  expected %0d %0d %0d %0d %0d %0d",
                        want.status, $signed(want.stress), want.tangent,
                        $signed(want.plastic), want.accum, want.yielded);
                    $display("  actual   %0d %0d %0d %0d %0d %0d ech=%0d",
                        got.status, $signed(got.stress), got.tangent,
                        $signed(got.plastic), got.accum, got.yielded, got.epoch);
                end
            end
        endfunction
    endclass

    localparam int WATCHDOG = 20000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;  // total_strain, step_epoch
    logic [1:0]   s_tuser = '0;  // req_type
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [207:0] m_tdata;       // stress, tangent, plastic, accum, yielded, epoch
    logic [1:0]   m_tuser;       // status
    logic         cfg_wr_en = 0;
    logic [1:0]   cfg_index = '0;
    logic [29:0]  cfg_wdata = '0;

    point_scoreboard board;
    int src_idle_pct, snk_idle_pct;
    int idle_cycles;
    bit timed_out;
    int n_trials, n_yields, n_commits;

    always #5 aclk = ~aclk;

    bilinear_plasticity_point DUT (.*);

    // result side: random stall and compare
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                board.check_word({m_tdata[47:0], m_tdata[77:48], m_tdata[109:78],
                                  m_tdata[141:110], m_tdata[142], m_tdata[206:143],
                                  m_tuser});
                if (m_tuser == bpp_pkg::STS_OK && m_tdata[142]) n_yields++;
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on stalled handshakes
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays up from one word to the next unless the sender idles
    task automatic send_word(logic [1:0] kind, logic [31:0] strain, logic [63:0] ep);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= {ep, strain};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(kind, strain, ep);
        if (kind == bpp_pkg::REQ_TRIAL) n_trials++;
        if (kind == bpp_pkg::REQ_COMMIT) n_commits++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [29:0] val);
        cfg_wr_en <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        board.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // strain around the yield point for the present settings
    function automatic logic [31:0] pick_strain();
        logic [63:0] ystrain;
        int sel;
        sel = $urandom_range(9);
        ystrain = (64'(board.y_str) << 30) / (board.e_mod == 0 ? 1 : board.e_mod);
        if (sel == 0 || ystrain > 64'h7FFFFFFF) return $urandom;
        ystrain = ystrain + $urandom_range(int'(ystrain[31:0]) / 2 + 4);
        if (ystrain > 64'h7FFFFFFF) ystrain = 64'h7FFFFFFF;
        if (sel < 4) return board.c_plastic + $urandom_range(int'(ystrain[31:0]));
        return $urandom_range(1) ? board.c_plastic + ystrain[31:0]
                                 : board.c_plastic - ystrain[31:0];
    endfunction

    // one load step: trial(s), then mostly commit, sometimes rollback or noise
    task automatic random_step();
        logic [63:0] nxt;
        int r;
        nxt = board.c_step + 1;
        r = $urandom_range(99);
        if (r < 6) begin
            send_word(2'($urandom_range(3)), $urandom, {$urandom, $urandom});
        end else if (r < 10) begin
            send_word($urandom_range(1) ? bpp_pkg::REQ_COMMIT : bpp_pkg::REQ_ROLLBACK,
                      $urandom, nxt);
        end else begin
            send_word(bpp_pkg::REQ_TRIAL, pick_strain(), nxt);
            if ($urandom_range(4) == 0) send_word(bpp_pkg::REQ_TRIAL, pick_strain(), nxt);
            r = $urandom_range(99);
            if (r < 70) send_word(bpp_pkg::REQ_COMMIT, $urandom, nxt);
            else if (r < 85) send_word(bpp_pkg::REQ_ROLLBACK, $urandom, nxt);
            else if (r < 92) send_word(bpp_pkg::REQ_COMMIT, $urandom, nxt + 1);
        end
    endtask

    initial begin
        logic [29:0] e_set[5];
        logic [29:0] y_set[5];
        logic [15:0] r_set[5];
        board = new();
        idle_cycles = 0; timed_out = 0;
        n_trials = 0; n_yields = 0; n_commits = 0;
        src_idle_pct = 27; snk_idle_pct = 75;
        e_set = '{30'd200000000, 30'h3FFFFFFF, 30'd1, 30'd70000000, 30'd1000};
        y_set = '{30'd250000, 30'd1, 30'h3FFFFFFF, 30'd100000, 30'd1};
        r_set = '{16'd0, 16'hFFFF, 16'd32768, 16'd6554, 16'd0};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: epoch checks, mismatches, extremes of strain
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd1);
        send_word(bpp_pkg::REQ_ROLLBACK, 0, 64'd1);
        send_word(bpp_pkg::REQ_UNUSED, 32'hFFFFFFFF, 64'd1);
        send_word(bpp_pkg::REQ_TRIAL, 32'h7FFFFFFF, 64'd0);
        send_word(bpp_pkg::REQ_TRIAL, 32'd1000, 64'hFFFFFFFFFFFFFFFF);
        send_word(bpp_pkg::REQ_TRIAL, 32'd1000, 64'd1);
        send_word(bpp_pkg::REQ_ROLLBACK, 0, 64'd1);
        send_word(bpp_pkg::REQ_TRIAL, 32'h7FFFFFFF, 64'd1);
        send_word(bpp_pkg::REQ_TRIAL, 32'h80000000, 64'd1);
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd2);
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd1);
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd1);
        send_word(bpp_pkg::REQ_TRIAL, 32'h7FFFFFFF, 64'd2);
        send_word(bpp_pkg::REQ_ROLLBACK, 32'hFFFFFFFF, 64'd2);
        drain();

        // strongest hardening and largest modulus
        write_reg(bpp_pkg::CFG_R, 16'hFFFF);
        write_reg(bpp_pkg::CFG_E, 30'h3FFFFFFF);
        write_reg(bpp_pkg::CFG_Y, 30'd1);
        send_word(bpp_pkg::REQ_TRIAL, 32'h7FFFFFFF, 64'd2);
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd2);
        send_word(bpp_pkg::REQ_TRIAL, 32'h80000000, 64'd3);
        send_word(bpp_pkg::REQ_TRIAL, 32'h00000000, 64'd3);
        send_word(bpp_pkg::REQ_COMMIT, 0, 64'd3);
        drain();

        // register sets cycled under the three idling profiles
        for (int ph = 0; ph < 15; ph++) begin
            if (ph == 5) begin
                src_idle_pct = 75; snk_idle_pct = 27;
            end
            if (ph == 10) begin
                src_idle_pct = 0; snk_idle_pct = 0;
            end
            write_reg(bpp_pkg::CFG_E, e_set[ph % 5]);
            write_reg(bpp_pkg::CFG_Y, y_set[ph % 5]);
            write_reg(bpp_pkg::CFG_R, r_set[ph % 5]);
            if (ph == 4) begin
                send_word(bpp_pkg::REQ_TRIAL, 32'd5, board.c_step + 1);
                send_word(bpp_pkg::REQ_COMMIT, 0, board.c_step + 1);
            end
            for (int i = 0; i < 30; i++) random_step();
            drain();
        end

        $display("run: %0d trials (%0d yielded), %0d commits, %0d words checked",
            n_trials, n_yields, n_commits, board.checked);
        $display("register sets covered unit and full-scale modulus, yield and ratio");
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
